@@ sv/cte_pkg.sv @@
`timescale 1ns / 1ps
package cte_pkg;

	localparam int unsigned ZoneW     = 18;
	localparam int unsigned SdcW      = 20;
	localparam int unsigned JdW       = 23;
	localparam int unsigned JdRelW    = 24;
	localparam int unsigned EpochW    = 40;
	localparam int unsigned CfgIdxW   = 1;

	localparam int unsigned JdAtEpoch  = 2440587;
	localparam int unsigned JdBase     = 1720994;
	localparam int unsigned FirstYear  = 1583;
	localparam int unsigned LastYear   = 10000;
	localparam int unsigned CenturyBase = 1900;
	localparam int unsigned SecPerDay  = 86400;
	localparam int unsigned SecPerHour = 3600;

	// year / 100 == (year * CentMul) >> CentShift for every 14-bit year
	localparam int unsigned CentMul   = 5243;
	localparam int unsigned CentShift = 19;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ZONE_OFFSET = 1'b0,
		REG_DAYLIGHT    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [5:0]  day_of_month;
		logic [3:0]  month_index;
		logic [13:0] year_value;
		logic [4:0]  hour_value;
		logic [5:0]  minute_value;
		logic [5:0]  second_value;
	} date_in_t;

	typedef struct packed {
		logic                     result_valid;
		logic [JdW-1:0]           julian_day;
		logic signed [EpochW-1:0] epoch_seconds;
	} result_t;

	// checked and adjusted date, time of day already zone corrected
	typedef struct packed {
		logic                   ok;
		logic [5:0]             day;
		logic [13:0]            year;
		logic [3:0]             mon;
		logic signed [SdcW-1:0] sdc;
	} chk_t;

	typedef struct packed {
		logic                     ok;
		logic [JdW-1:0]           jd;
		logic signed [JdRelW-1:0] jd_rel;
		logic signed [SdcW-1:0]   sdc;
	} jd_t;

	// (306001 * (mon + 1)) / 10000 for the shifted months March..February
	function automatic logic [8:0] month_days(input logic [3:0] mon);
		logic [8:0] r;
		case (mon)
			4'd3:    r = 9'd122;
			4'd4:    r = 9'd153;
			4'd5:    r = 9'd183;
			4'd6:    r = 9'd214;
			4'd7:    r = 9'd244;
			4'd8:    r = 9'd275;
			4'd9:    r = 9'd306;
			4'd10:   r = 9'd336;
			4'd11:   r = 9'd367;
			4'd12:   r = 9'd397;
			4'd13:   r = 9'd428;
			4'd14:   r = 9'd459;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/calendar_to_epoch_seconds_top.sv @@
`timescale 1ns / 1ps
// Channel   | Ports                               | Transfer
// ----------+-------------------------------------+----------------------------------
// date in   | start, busy, date_in                | edge with start high, busy low
// result    | done, result                        | edge that ends the cycle done is high
// config    | wr_en, wr_index, wr_data            | edge with wr_en high
//
// One date enters every cycle; busy is never raised.
// Each result passes through the stages below and shows one cycle wide.
// The stages are: check and zone adjust, year terms, day sum, day scaling, final add.
// Reset clears the valid bits and the two settings; data registers are not reset.
// The receiver cannot stall, so nothing in the pipe ever holds.
module calendar_to_epoch_seconds_top
	import cte_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  date_in_t           date_in,
	output logic               done,
	output result_t            result,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [ZoneW-1:0]   wr_data
);

	logic signed [ZoneW-1:0] zone_q;
	logic                    dst_q;
	logic                    valid_s1;
	logic                    valid_s3;
	chk_t                    chk_s1;
	jd_t                     jd_s3;

	// the pipe takes a date on every cycle
	assign busy = 1'b0;

	// settings registers; the user must write them only while the pipe is empty, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
			dst_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_ZONE_OFFSET: zone_q <= $signed(wr_data);
				REG_DAYLIGHT:    dst_q  <= wr_data[0];
				default:         ;
			endcase
		end
	end

	// stage 1: validate, shift January and February, zone corrected time of day
	cte_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.date_in  (date_in),
		.zone_q   (zone_q),
		.dst_q    (dst_q),
		.valid_s1 (valid_s1),
		.chk_s1   (chk_s1)
	);

	// stages 2 and 3: century, leap and month terms, then the Julian day sum
	cte_jd u_jd (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.chk_s1   (chk_s1),
		.valid_s3 (valid_s3),
		.jd_s3    (jd_s3)
	);

	// stages 4 and 5: days since the epoch times 86400, plus time of day
	cte_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.jd_s3     (jd_s3),
		.valid_s5  (done),
		.result_s5 (result)
	);

endmodule

@@ sv/cte_check.sv @@
`timescale 1ns / 1ps
module cte_check
	import cte_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  date_in_t                date_in,
	input  logic signed [ZoneW-1:0] zone_q,
	input  logic                    dst_q,
	output logic                    valid_s1,
	output chk_t                    chk_s1
);

	logic [13:0]            year_c;
	logic [13:0]            year_adj;
	logic [3:0]             mon_c;
	logic                   early;
	logic                   fields_ok;
	logic [16:0]            tod;
	logic signed [SdcW-1:0] sdc_c;

	always_comb begin
		early    = (date_in.month_index <= 4'd1);
		year_c   = (date_in.year_value < 14'd100) ?
			date_in.year_value + 14'(CenturyBase) : date_in.year_value;
		year_adj = early ? year_c - 14'd1 : year_c;
		mon_c    = early ? date_in.month_index + 4'd13 : date_in.month_index + 4'd1;

		fields_ok = (date_in.day_of_month >= 6'd1) && (date_in.day_of_month <= 6'd31)
			&& (date_in.month_index <= 4'd11)
			&& (date_in.year_value >= 14'd1) && (date_in.year_value <= 14'(LastYear))
			&& (date_in.hour_value <= 5'd23) && (date_in.minute_value <= 6'd59)
			&& (date_in.second_value <= 6'd59);

		tod = 17'(date_in.hour_value) * 17'(SecPerHour)
			+ 17'(date_in.minute_value) * 17'd60 + 17'(date_in.second_value);
		sdc_c = $signed({3'b000, tod}) - SdcW'(zone_q)
			- (dst_q ? SdcW'(SecPerHour) : SdcW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		chk_s1.ok   <= fields_ok && (year_adj >= 14'(FirstYear));
		chk_s1.day  <= date_in.day_of_month;
		chk_s1.year <= year_adj;
		chk_s1.mon  <= mon_c;
		chk_s1.sdc  <= sdc_c;
	end

endmodule

@@ sv/cte_jd.sv @@
`timescale 1ns / 1ps
module cte_jd
	import cte_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  chk_t chk_s1,
	output logic valid_s3,
	output jd_t  jd_s3
);

	logic                   valid_s2;
	logic                   ok_s2;
	logic [5:0]             day_s2;
	logic [7:0]             cent_s2;
	logic [11:0]            q4_s2;
	logic [JdW-1:0]         y365_s2;
	logic [8:0]             mt_s2;
	logic signed [SdcW-1:0] sdc_s2;

	logic [26:0]    cent_prod;
	logic [JdW-1:0] jd_sum;

	assign cent_prod = 27'(chk_s1.year) * 27'(CentMul);

	always_comb begin
		jd_sum = JdW'(day_s2) + JdW'(cent_s2 >> 2) + y365_s2 + JdW'(q4_s2)
			+ JdW'(mt_s2) + JdW'(JdBase + 2) - JdW'(cent_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// split the year terms, then sum them
	always_ff @(posedge clk) begin
		ok_s2   <= chk_s1.ok;
		day_s2  <= chk_s1.day;
		cent_s2 <= cent_prod[CentShift +: 8];
		q4_s2   <= chk_s1.year[13:2];
		y365_s2 <= JdW'(chk_s1.year) * JdW'(365);
		mt_s2   <= month_days(chk_s1.mon);
		sdc_s2  <= chk_s1.sdc;

		jd_s3.ok     <= ok_s2;
		jd_s3.jd     <= jd_sum;
		jd_s3.jd_rel <= $signed({1'b0, jd_sum}) - JdRelW'(JdAtEpoch);
		jd_s3.sdc    <= sdc_s2;
	end

endmodule

@@ sv/cte_scale.sv @@
`timescale 1ns / 1ps
module cte_scale
	import cte_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s3,
	input  jd_t     jd_s3,
	output logic    valid_s5,
	output result_t result_s5
);

	logic                     valid_s4;
	logic                     ok_s4;
	logic [JdW-1:0]           jd_s4;
	logic signed [EpochW:0]   prod_full;
	logic signed [EpochW-1:0] prod_s4;
	logic signed [SdcW-1:0]   sdc_s4;

	assign prod_full = $signed({{(EpochW + 1 - JdRelW){jd_s3.jd_rel[JdRelW-1]}}, jd_s3.jd_rel})
		* $signed((EpochW + 1)'(SecPerDay));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4   <= jd_s3.ok;
		jd_s4   <= jd_s3.jd;
		prod_s4 <= prod_full[EpochW-1:0];
		sdc_s4  <= jd_s3.sdc;

		// drop the numbers of a rejected date
		result_s5.result_valid  <= ok_s4;
		result_s5.julian_day    <= ok_s4 ? jd_s4 : '0;
		result_s5.epoch_seconds <= ok_s4 ? prod_s4 + EpochW'(sdc_s4) : '0;
	end

endmodule

@@ bench/tb_calendar_to_epoch_seconds_top.sv @@
`timescale 1ns / 1ps
module tb_calendar_to_epoch_seconds_top;
	import cte_pkg::*;

	localparam int unsigned ClkHalf      = 2;
	localparam int unsigned ResetCycles  = 9;
	// the result comes back through the pipe after its transfer; leave some slack
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned TailCycles   = 12;
	localparam int unsigned PhaseCount   = 8;
	localparam int unsigned PhaseDates   = 234;

	// one entry of the sender's work list: a date, a register write, or a wait
	// until every expected result has come back
	typedef enum logic [1:0] {
		OP_DATE,
		OP_CFG,
		OP_DRAIN
	} op_kind_t;

	typedef struct {
		op_kind_t         kind;
		date_in_t         date;
		cfg_reg_t         reg_sel;
		logic [ZoneW-1:0] value;
	} pending_op_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic               busy;
	date_in_t           date_in  = '0;
	logic               done;
	result_t            result;
	logic               wr_en    = 1'b0;
	logic [CfgIdxW-1:0] wr_index = REG_ZONE_OFFSET;
	logic [ZoneW-1:0]   wr_data  = '0;

	pending_op_t pending_ops[$];
	result_t     expected_results[$];

	// shadow copy of the two settings, updated when the write is issued
	logic signed [ZoneW-1:0] zone_shadow = '0;
	logic                    dst_shadow  = 1'b0;

	int unsigned error_count  = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left   = 1;
	int unsigned gap_left     = 0;

	calendar_to_epoch_seconds_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.date_in  (date_in),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #(ClkHalf) clk = ~clk;

	// Julian day and epoch seconds for one date under the current settings
	function automatic result_t predict_result(input date_in_t d);
		longint day, mon, yr, cent, jd, tod, epoch;
		bit     ok;
		result_t r;
		day = longint'(d.day_of_month);
		mon = longint'(d.month_index) + 1;
		yr  = longint'(d.year_value);
		ok  = day >= 1 && day <= 31 && mon <= 12 && yr >= 1 && yr <= longint'(LastYear)
			&& d.hour_value <= 23 && d.minute_value <= 59 && d.second_value <= 59;
		// two-digit years belong to the 1900s
		if (yr < 100)
			yr += longint'(CenturyBase);
		// January and February close the previous year
		if (mon <= 2) begin
			yr  -= 1;
			mon += 12;
		end
		if (yr < longint'(FirstYear))
			ok = 1'b0;
		r = '0;
		if (ok) begin
			cent = yr / 100;
			jd   = day + 2 - cent + cent / 4 + yr * 365 + yr / 4
				+ (306001 * (mon + 1)) / 10000 + longint'(JdBase);
			// time of day may go negative here; that is still a valid result
			tod  = (longint'(d.hour_value) * 60 + longint'(d.minute_value)) * 60
				+ longint'(d.second_value) - longint'(zone_shadow);
			if (dst_shadow)
				tod -= longint'(SecPerHour);
			epoch = (jd - longint'(JdAtEpoch)) * longint'(SecPerDay) + tod;
			r.result_valid  = 1'b1;
			r.julian_day    = jd[JdW-1:0];
			r.epoch_seconds = epoch[EpochW-1:0];
		end
		return r;
	endfunction

	function automatic date_in_t make_date(input int day, input int mon, input int yr,
			input int hr, input int mi, input int se);
		date_in_t d;
		d.day_of_month = day[5:0];
		d.month_index  = mon[3:0];
		d.year_value   = yr[13:0];
		d.hour_value   = hr[4:0];
		d.minute_value = mi[5:0];
		d.second_value = se[5:0];
		return d;
	endfunction

	// mostly well-formed dates with random content, the rest raw noise
	function automatic date_in_t random_date();
		logic [63:0] raw;
		date_in_t    d;
		raw = {$urandom, $urandom};
		d   = raw[$bits(date_in_t)-1:0];
		if ($urandom_range(0, 9) < 8) begin
			d.day_of_month = 6'($urandom_range(1, 31));
			d.month_index  = 4'($urandom_range(0, 11));
			case ($urandom_range(0, 3))
				0:       d.year_value = 14'($urandom_range(1, 99));
				1:       d.year_value = 14'($urandom_range(FirstYear, 2100));
				default: d.year_value = 14'($urandom_range(FirstYear, LastYear));
			endcase
			d.hour_value   = 5'($urandom_range(0, 23));
			d.minute_value = 6'($urandom_range(0, 59));
			d.second_value = 6'($urandom_range(0, 59));
		end
		return d;
	endfunction

	task automatic queue_date(input date_in_t d);
		pending_op_t op;
		op.kind    = OP_DATE;
		op.date    = d;
		op.reg_sel = REG_ZONE_OFFSET;
		op.value   = '0;
		pending_ops.push_back(op);
	endtask

	task automatic queue_config(input cfg_reg_t r, input logic [ZoneW-1:0] v);
		pending_op_t op;
		op.kind    = OP_CFG;
		op.date    = '0;
		op.reg_sel = r;
		op.value   = v;
		pending_ops.push_back(op);
	endtask

	task automatic queue_drain();
		pending_op_t op;
		op.kind    = OP_DRAIN;
		op.date    = '0;
		op.reg_sel = REG_ZONE_OFFSET;
		op.value   = '0;
		pending_ops.push_back(op);
	endtask

	// Sender: record each date transfer, then pick the next action from the work
	// list. Dates go out in bursts with random gaps; register writes wait until
	// the pipe has been quiet for a while.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		pending_op_t op;
		logic        next_start;
		date_in_t    next_date;
		logic        next_wr;
		if (!arst_n) begin
			start   <= 1'b0;
			date_in <= '0;
			wr_en   <= 1'b0;
		end else begin
			next_start = start;
			next_date  = date_in;
			next_wr    = 1'b0;
			if (start && !busy) begin
				expected_results.push_back(predict_result(date_in));
				next_start = 1'b0;
			end
			// count quiet cycles: no date in flight, nothing outstanding
			if (!start && expected_results.size() == 0)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			// hold start and the date while busy; otherwise advance
			if (!next_start && pending_ops.size() != 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_DATE: begin
						if (gap_left != 0) begin
							gap_left--;
						end else begin
							next_start = 1'b1;
							next_date  = op.date;
							void'(pending_ops.pop_front());
							burst_left--;
							if (burst_left == 0) begin
								burst_left = $urandom_range(1, 48);
								gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
							end
						end
					end
					OP_CFG: begin
						if (quiet_cycles >= SettleCycles) begin
							next_wr  = 1'b1;
							wr_index <= op.reg_sel;
							wr_data  <= op.value;
							if (op.reg_sel == REG_ZONE_OFFSET)
								zone_shadow = op.value;
							else
								dst_shadow = op.value[0];
							void'(pending_ops.pop_front());
						end
					end
					default: begin
						if (expected_results.size() == 0)
							void'(pending_ops.pop_front());
					end
				endcase
			end
			start   <= next_start;
			date_in <= next_date;
			wr_en   <= next_wr;
		end
	end

	// Receiver: every strobed result must match the oldest outstanding date.
	always @(posedge clk) begin : check_proc
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result_valid: expected no result, got %0d", result.result_valid);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.result_valid !== want.result_valid) begin
					$error("result_valid: expected %0d, got %0d",
						want.result_valid, result.result_valid);
					error_count++;
				end
				if (result.julian_day !== want.julian_day) begin
					$error("julian_day: expected %0d, got %0d",
						want.julian_day, result.julian_day);
					error_count++;
				end
				if (result.epoch_seconds !== want.epoch_seconds) begin
					$error("epoch_seconds: expected %0d, got %0d",
						want.epoch_seconds, result.epoch_seconds);
					error_count++;
				end
			end
		end
	end

	initial begin : stim_proc
		logic [ZoneW-1:0] zone;
		logic [ZoneW-1:0] dst_word;
		// directed dates under the reset settings
		queue_date(make_date(1, 0, 1970, 0, 0, 0));      // the epoch itself
		queue_date(make_date(31, 11, 10000, 23, 59, 59)); // latest valid instant
		queue_date(make_date(1, 2, 1583, 0, 0, 0));      // earliest valid date
		queue_date(make_date(28, 1, 1583, 12, 0, 0));    // February falls back to 1582
		queue_date(make_date(1, 0, 1, 0, 0, 0));         // two-digit year 1901
		queue_date(make_date(31, 11, 99, 23, 59, 59));   // two-digit year 1999
		queue_date(make_date(1, 5, 100, 1, 1, 1));       // year 100 is too early
		queue_date(make_date(1, 5, 0, 1, 1, 1));
		queue_date(make_date(1, 5, 10001, 1, 1, 1));
		queue_date(make_date(1, 5, 16383, 1, 1, 1));
		queue_date(make_date(0, 5, 2020, 1, 1, 1));
		queue_date(make_date(32, 5, 2020, 1, 1, 1));
		queue_date(make_date(63, 5, 2020, 1, 1, 1));
		queue_date(make_date(15, 12, 2020, 1, 1, 1));
		queue_date(make_date(15, 15, 2020, 1, 1, 1));
		queue_date(make_date(15, 6, 2020, 24, 1, 1));
		queue_date(make_date(15, 6, 2020, 31, 1, 1));
		queue_date(make_date(15, 6, 2020, 1, 60, 1));
		queue_date(make_date(15, 6, 2020, 1, 63, 1));
		queue_date(make_date(15, 6, 2020, 1, 1, 60));
		queue_date(make_date(15, 6, 2020, 1, 1, 63));
		queue_date(make_date(31, 1, 2001, 6, 30, 0));    // day past the month's end
		queue_date(make_date(29, 1, 2000, 12, 34, 56));
		// midnight one second east of zero gives a time of day of minus one
		queue_drain();
		queue_config(REG_ZONE_OFFSET, 18'sd1);
		queue_date(make_date(1, 0, 1970, 0, 0, 0));
		queue_date(make_date(1, 2, 1583, 0, 0, 0));

		// random phases, each under its own settings, extremes included
		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0:       zone = 18'sd0;
				1:       zone = 18'sh1FFFF;
				2:       zone = 18'sh20000;
				3:       zone = 18'sd86400;
				4:       zone = -18'sd86400;
				5:       zone = 18'sd3600;
				default: zone = 18'($urandom);
			endcase
			// random upper bits on the daylight write; only bit 0 counts
			dst_word = 18'($urandom);
			dst_word[0] = p[0];
			queue_drain();
			queue_config(REG_ZONE_OFFSET, zone);
			queue_config(REG_DAYLIGHT, dst_word);
			for (int i = 0; i < PhaseDates; i++)
				queue_date(random_date());
		end

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin : watchdog_proc
		#(2_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
